FILE: sv/ttta_pkg.sv
// ----------------------------------------------------------------------------
// ttta_pkg
// Shared command and status codes and the controller/datapath link types
// of the transaction table id allocator.
// ----------------------------------------------------------------------------
package ttta_pkg;

  // request commands
  localparam logic [2:0] CMD_FIND_ID   = 3'd0;
  localparam logic [2:0] CMD_FIND_CREF = 3'd1;
  localparam logic [2:0] CMD_INSERT    = 3'd2;
  localparam logic [2:0] CMD_FREE      = 3'd3;
  localparam logic [2:0] CMD_ASSIGN    = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NO_ID     = 3'd3;
  localparam logic [2:0] ST_BAD_SLOT  = 3'd4;

  // id allocation
  localparam logic [7:0] ID_UNASSIGNED = 8'hff;
  localparam int         ID_SPACE      = 16;
  localparam logic [3:0] ID_MOD        = 4'd7;
  localparam int         ID_TOP        = 6;

  typedef struct packed {
    logic start;
    logic walk_en;
    logic scan_en;
    logic insert_wr;
    logic free_commit;
    logic idh;
    logic deliver;
  } ctl_t;

  typedef struct packed {
    logic is_find;
    logic is_insert;
    logic is_free;
    logic is_assign;
    logic full;
    logic bad_slot;
    logic walk_done;
    logic scan_hit;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/ttta_ctrl.sv
// ----------------------------------------------------------------------------
// ttta_ctrl
// Sequencer: takes one request, steers the datapath through the table walk,
// free-slot scan or id search, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ttta_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  output ttta_pkg::ctl_t  ctl,
  input  ttta_pkg::sts_t  sts
);
  import ttta_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_IDH    = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state, state_next;

  always_comb begin
    ctl        = '0;
    state_next = state;
    req_stall  = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.start  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.is_find || sts.is_assign) begin
          state_next = S_WALK;
        end else if (sts.is_free) begin
          state_next = sts.bad_slot ? S_RESULT : S_WALK;
        end else if (sts.is_insert) begin
          state_next = sts.full ? S_RESULT : S_SCAN;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_WALK: begin
        ctl.walk_en = 1'b1;
        if (sts.walk_done) begin
          priority if (sts.is_free) begin
            ctl.free_commit = 1'b1;
            state_next      = S_RESULT;
          end else if (sts.is_assign) begin
            state_next = S_IDH;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        ctl.scan_en = 1'b1;
        if (sts.scan_hit) begin
          ctl.insert_wr = 1'b1;
          state_next    = S_RESULT;
        end
      end
      S_IDH: begin
        ctl.idh    = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          ctl.deliver = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/ttta_dp.sv
// ----------------------------------------------------------------------------
// ttta_dp
// Datapath: entry memories, insertion order list, walk pipeline, free-slot
// scan, used-id mask with circular id search, and the output register.
// ----------------------------------------------------------------------------
module ttta_dp #(
  parameter int ENTRIES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  ttta_pkg::ctl_t  ctl,
  output ttta_pkg::sts_t  sts,
  input  logic [2:0]      command,
  input  logic [3:0]      protocol,
  input  logic [7:0]      txn_id,
  input  logic [31:0]     call_reference,
  input  logic            flag_bit,
  input  logic [3:0]      slot,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output logic [2:0]      status,
  output logic [3:0]      slot_out,
  output logic [3:0]      assigned_id
);
  import ttta_pkg::*;

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // latched request
  logic [2:0]  cmd_q;
  logic [3:0]  proto_q;
  logic [7:0]  tid_q;
  logic [31:0] cref_q;
  logic        flag_q;
  logic [3:0]  slot_q;
  logic        full_q;
  logic        bad_q;

  logic [ENTRIES-1:0] valid;
  logic [CW-1:0]      count;

  logic [SW-1:0] order_mem [ENTRIES];
  logic [3:0]    prot_mem  [ENTRIES];
  logic [7:0]    id_mem    [ENTRIES];
  logic [31:0]   cref_mem  [ENTRIES];
  logic [SW-1:0] order_q;
  logic [3:0]    prot_rd;
  logic [7:0]    id_rd;
  logic [31:0]   cref_rd;

  // walk pipeline: order read, entry read, compare
  logic [CW-1:0] k;
  logic          v1, v2;
  logic [SW-1:0] k1, s2;
  logic          issue;
  logic          hit_q, shift_q;
  logic [SW-1:0] hit_slot;

  logic [ID_SPACE-1:0] used;
  logic [2:0]          h_c, h_q;
  logic [SW-1:0]       f;
  logic [SW-1:0]       slot_idx;

  logic        is_find, is_free, is_assign;
  logic        match, use_ok;
  logic        sel_found;
  logic [3:0]  sel_id;
  logic [2:0]  res_status;
  logic [3:0]  res_slot, res_id;
  logic        shift_wr;

  assign slot_idx  = SW'(slot_q);
  assign is_find   = (cmd_q == CMD_FIND_ID) || (cmd_q == CMD_FIND_CREF);
  assign is_free   = (cmd_q == CMD_FREE);
  assign is_assign = (cmd_q == CMD_ASSIGN);
  assign issue     = ctl.walk_en && (k < count);
  assign shift_wr  = ctl.walk_en && v1 && shift_q;

  assign match = (cmd_q == CMD_FIND_ID) ? ((prot_rd == proto_q) && (id_rd == tid_q))
                                        : (cref_rd == cref_q);
  assign use_ok = (prot_rd == proto_q) && (id_rd != ID_UNASSIGNED) &&
                  (id_rd < 8'(ID_SPACE));

  always_comb begin
    sts.is_find   = is_find;
    sts.is_insert = (cmd_q == CMD_INSERT);
    sts.is_free   = is_free;
    sts.is_assign = is_assign;
    sts.full      = full_q;
    sts.bad_slot  = bad_q;
    sts.walk_done = (is_find && hit_q) || ((k == count) && !v1 && !v2);
    sts.scan_hit  = !valid[f];
    sts.out_free  = !rsp_valid || !rsp_stall;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      count     <= '0;
      k         <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      hit_q     <= 1'b0;
      shift_q   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.insert_wr) begin
        valid[f] <= 1'b1;
        count    <= count + 1'b1;
      end
      if (ctl.free_commit) begin
        valid[slot_idx] <= 1'b0;
        count           <= count - 1'b1;
      end
      if (ctl.start) begin
        k       <= '0;
        v1      <= 1'b0;
        v2      <= 1'b0;
        hit_q   <= 1'b0;
        shift_q <= 1'b0;
      end else if (ctl.walk_en) begin
        if (issue) begin
          k <= k + 1'b1;
        end
        v1 <= issue;
        v2 <= v1;
        if (v1 && is_free && !shift_q && (order_q == slot_idx)) begin
          shift_q <= 1'b1;
        end
        if (v2 && is_find && !hit_q && match) begin
          hit_q <= 1'b1;
        end
      end
      if (ctl.deliver) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd_q   <= command;
      proto_q <= protocol;
      tid_q   <= txn_id;
      cref_q  <= call_reference;
      flag_q  <= flag_bit;
      slot_q  <= slot;
      full_q  <= (count == CW'(ENTRIES));
      bad_q   <= (32'(slot) >= 32'(ENTRIES)) || !valid[SW'(slot)];
      used    <= '0;
      f       <= '0;
    end else begin
      if (ctl.walk_en && v2 && is_assign && use_ok) begin
        used[id_rd[3:0]] <= 1'b1;
      end
      if (ctl.scan_en && valid[f]) begin
        f <= f + 1'b1;
      end
    end
    if (issue) begin
      k1 <= SW'(k);
    end
    if (ctl.walk_en && v1) begin
      s2 <= order_q;
    end
    if (ctl.walk_en && v2 && is_find && !hit_q && match) begin
      hit_slot <= s2;
    end
    if (ctl.idh) begin
      h_q <= h_c;
    end
    if (ctl.deliver) begin
      status      <= res_status;
      slot_out    <= res_slot;
      assigned_id <= res_id;
    end
  end

  // insertion order list
  always_ff @(posedge clk) begin
    if (ctl.insert_wr) begin
      order_mem[SW'(count)] <= f;
    end else if (shift_wr) begin
      order_mem[k1 - 1'b1] <= order_q;
    end
    order_q <= order_mem[SW'(k)];
  end

  // entry fields
  always_ff @(posedge clk) begin
    if (ctl.insert_wr) begin
      prot_mem[f] <= proto_q;
      id_mem[f]   <= tid_q;
      cref_mem[f] <= cref_q;
    end
    prot_rd <= prot_mem[order_q];
    id_rd   <= id_mem[order_q];
    cref_rd <= cref_mem[order_q];
  end

  // highest used id from 1 to ID_TOP, in the flagged or plain half
  always_comb begin
    h_c = 3'd0;
    for (int i = 1; i <= ID_TOP; i++) begin
      if (used[{flag_q, 3'(i)}]) begin
        h_c = 3'(i);
      end
    end
  end

  // circular search from h, first free candidate wins
  always_comb begin
    logic [3:0] tsum;
    sel_found = 1'b0;
    sel_id    = '0;
    for (int i = ID_TOP; i >= 0; i--) begin
      tsum = {1'b0, h_q} + 4'(i);
      if (tsum >= ID_MOD) begin
        tsum = tsum - ID_MOD;
      end
      if (!used[{flag_q, tsum[2:0]}]) begin
        sel_found = 1'b1;
        sel_id    = {flag_q, tsum[2:0]};
      end
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_slot   = '0;
    res_id     = '0;
    unique case (cmd_q)
      CMD_FIND_ID, CMD_FIND_CREF: begin
        if (hit_q) begin
          res_slot = 4'(hit_slot);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      CMD_INSERT: begin
        if (full_q) begin
          res_status = ST_FULL;
        end else begin
          res_slot = 4'(f);
        end
      end
      CMD_FREE: begin
        if (bad_q) begin
          res_status = ST_BAD_SLOT;
        end
      end
      CMD_ASSIGN: begin
        if (sel_found) begin
          res_id = sel_id;
        end else begin
          res_status = ST_NO_ID;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

endmodule

FILE: sv/transaction_table_tid_allocator.sv
// ----------------------------------------------------------------------------
// transaction_table_tid_allocator
// Transaction table with lookup, insert, free and transaction id assignment.
// ----------------------------------------------------------------------------
// Usage:
//   request channel  req_valid / req_stall with command, protocol, txn_id,
//                    call_reference, flag_bit and slot; one request at a time
//   response channel rsp_valid / rsp_stall with status, slot_out and
//                    assigned_id; exactly one response per request
// Find, free and assign id walk the insertion order list, one entry per
// cycle; a find stops early on a hit, and assign id then searches for a
// free id. Insert scans for the lowest free slot. A full table, a bad
// slot or any other command goes straight to the result. Each walked
// entry passes an order memory read and an entry memory read before its
// compare. The next request is taken in the cycle after the response is
// loaded.
// The response sits in an output register; the next request is taken while
// it waits. A stalled response holds until taken, and a request that
// finishes meanwhile waits in the sequencer with req_stall high.
// Reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module transaction_table_tid_allocator #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  command,
  input  logic [3:0]  protocol,
  input  logic [7:0]  txn_id,
  input  logic [31:0] call_reference,
  input  logic        flag_bit,
  input  logic [3:0]  slot,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  status,
  output logic [3:0]  slot_out,
  output logic [3:0]  assigned_id
);
  import ttta_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ttta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  ttta_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .command        (command),
    .protocol       (protocol),
    .txn_id         (txn_id),
    .call_reference (call_reference),
    .flag_bit       (flag_bit),
    .slot           (slot),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .slot_out       (slot_out),
    .assigned_id    (assigned_id)
  );

endmodule
